FILE: src/hrlp_pkg.sv
package hrlp_pkg;

   localparam int ByteWidth    = 8;
   localparam int CharWidth    = 7;
   localparam int VersionWidth = 10;
   localparam int CountWidth   = 3;
   localparam int RspDataWidth = 32;

   localparam logic [ByteWidth-1:0] CHAR_CR      = 8'h0D;
   localparam logic [ByteWidth-1:0] CHAR_LF      = 8'h0A;
   localparam logic [ByteWidth-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [ByteWidth-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [ByteWidth-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [ByteWidth-1:0] CHAR_DOT     = 8'h2E;
   localparam logic [ByteWidth-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [ByteWidth-1:0] CHAR_NINE    = 8'h39;

   localparam logic [31:0] WORD_GET  = 32'h0047_4554;
   localparam logic [31:0] WORD_HEAD = 32'h4845_4144;
   localparam logic [31:0] WORD_POST = 32'h504F_5354;
   localparam logic [31:0] WORD_HTTP = 32'h4854_5450;

   localparam logic [VersionWidth-1:0] VERSION_MAX = 10'd999;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LINE   = 2'd1,
      STATUS_BAD_ESCAPE = 2'd2,
      STATUS_BAD_ENDING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      METHOD_GET  = 2'd0,
      METHOD_HEAD = 2'd1,
      METHOD_POST = 2'd2
   } request_method_type;

   typedef enum logic [1:0] {
      FIELD_METHOD  = 2'd0,
      FIELD_URL     = 2'd1,
      FIELD_VERSION = 2'd2
   } field_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } escape_type;

   typedef enum logic [1:0] {
      VER_PROTO = 2'd0,
      VER_MAJOR = 2'd1,
      VER_MINOR = 2'd2,
      VER_BAD   = 2'd3
   } version_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_FORMAT = 2'd1,
      ERR_URL    = 2'd2
   } error_type;

   // bit 4 set marks a byte that is not a hex digit
   function automatic logic [4:0] hex_value(input logic [ByteWidth-1:0] b);
      logic [4:0] v;
      v = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
      else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
         v = {1'b0, b[3:0] + 4'd9};
      return v;
   endfunction

   function automatic logic [VersionWidth-1:0] add_digit(
      input logic [VersionWidth-1:0] v,
      input logic [3:0]              d
   );
      logic [13:0] n;
      n = {4'd0, v} * 14'd10 + {10'd0, d};
      return (n > {4'd0, VERSION_MAX}) ? VERSION_MAX : n[VersionWidth-1:0];
   endfunction

endpackage

FILE: src/http_request_line_parser_unit.sv
// Request line parser: one byte of the line per req transaction, one result per byte.
// Each accepted byte goes into an input register and its result moves into the result
// register when that register is empty or being drained, so the unit sustains one byte
// per cycle while rsp_tready holds high; the single decode step between the two
// registers sets that rate. rsp_tuser flags a decoded URL byte, rsp_tlast marks the
// byte that ends the line (CR LF, a lone LF, or the byte after a CR) and carries
// status, method and version. The line state clears itself after every line end.
module http_request_line_parser_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hrlp_pkg::ByteWidth-1:0]   req_tdata,   // [7:0] in_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hrlp_pkg::RspDataWidth-1:0] rsp_tdata,  // [6:0] url_char, [8:7] status,
                                                         // [10:9] method_code,
                                                         // [20:11] version_major,
                                                         // [30:21] version_minor, [31] 0
   output logic                             rsp_tuser,   // [0] url_valid
   output logic                             rsp_tlast    // line_done
);
   import hrlp_pkg::*;

   // input stage
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 advance;

   // line state
   field_type              field_ff, field_in;
   logic [31:0]            method_chars_ff, method_chars_in;
   logic [CountWidth-1:0]  method_count_ff, method_count_in;
   logic [1:0]             space_count_ff, space_count_in;
   logic                   url_seen_ff, url_seen_in;
   escape_type             escape_ff, escape_in;
   logic [3:0]             escape_high_ff, escape_high_in;
   logic [31:0]            proto_chars_ff, proto_chars_in;
   logic [CountWidth-1:0]  proto_count_ff, proto_count_in;
   version_type            version_ff, version_in;
   logic [VersionWidth-1:0] major_ff, major_in;
   logic [VersionWidth-1:0] minor_ff, minor_in;
   error_type              error_ff, error_in;
   logic                   cr_pending_ff, cr_pending_in;
   logic                   digit_seen_ff, digit_seen_in;

   // result register
   logic                    rsp_valid_ff;
   logic                    url_valid_ff, url_valid_in;
   logic [CharWidth-1:0]    url_char_ff, url_char_in;
   logic                    line_done_ff, line_done_in;
   status_type              status_ff, status_in;
   request_method_type      method_ff, method_in;
   logic [VersionWidth-1:0] ver_major_ff, ver_major_in;
   logic [VersionWidth-1:0] ver_minor_ff, ver_minor_in;

   // decode of the byte in the input register
   logic                 is_cr, is_lf, is_space, is_digit, line_end, forced_end;
   logic                 get_ok, head_ok, post_ok, method_ok;
   logic                 line_fmt_bad, line_url_bad;
   logic [4:0]           hex_nib;
   logic [ByteWidth-1:0] esc_value;
   logic                 url_active;
   error_type            url_err_base;
   logic                 url_emit;
   logic [1:0]           space_next;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign is_cr    = (in_byte_ff == CHAR_CR);
   assign is_lf    = (in_byte_ff == CHAR_LF);
   assign is_space = (in_byte_ff == CHAR_SPACE);
   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);

   assign line_end   = cr_pending_ff || (!is_cr && is_lf);
   assign forced_end = cr_pending_ff ? !is_lf : 1'b1;

   assign get_ok    = (method_count_ff == 3'd3) && (method_chars_ff == WORD_GET);
   assign head_ok   = (method_count_ff == 3'd4) && (method_chars_ff == WORD_HEAD);
   assign post_ok   = (method_count_ff == 3'd4) && (method_chars_ff == WORD_POST);
   assign method_ok = get_ok || head_ok || post_ok;

   assign line_fmt_bad = (error_ff == ERR_FORMAT) || (space_count_ff != 2'd2) || !method_ok ||
                         !url_seen_ff || (version_ff != VER_MINOR) || !digit_seen_ff;
   assign line_url_bad = (error_ff == ERR_URL) || (escape_ff != ESC_NONE);

   assign hex_nib   = hex_value(in_byte_ff);
   assign esc_value = {escape_high_ff, hex_nib[3:0]};

   assign url_active = !cr_pending_ff && !is_cr && !is_lf && !is_space &&
                       (field_ff == FIELD_URL);
   // the first URL byte must be a slash
   assign url_err_base = (!url_seen_ff && (in_byte_ff != CHAR_SLASH)) ? ERR_FORMAT : error_ff;
   assign url_emit = url_active && (url_err_base != ERR_URL) &&
                     (((escape_ff == ESC_NONE) && (in_byte_ff != CHAR_PERCENT) &&
                       !in_byte_ff[7]) ||
                      ((escape_ff == ESC_LOW) && !hex_nib[4] && !esc_value[7]));

   assign space_next = (space_count_ff < 2'd3) ? space_count_ff + 2'd1 : space_count_ff;

   // next state
   always_comb begin
      field_in        = field_ff;
      method_chars_in = method_chars_ff;
      method_count_in = method_count_ff;
      space_count_in  = space_count_ff;
      url_seen_in     = url_seen_ff;
      escape_in       = escape_ff;
      escape_high_in  = escape_high_ff;
      proto_chars_in  = proto_chars_ff;
      proto_count_in  = proto_count_ff;
      version_in      = version_ff;
      major_in        = major_ff;
      minor_in        = minor_ff;
      error_in        = error_ff;
      cr_pending_in   = cr_pending_ff;
      digit_seen_in   = digit_seen_ff;
      if (advance) begin
         priority if (line_end) begin
            // clear for the next line
            field_in        = FIELD_METHOD;
            method_chars_in = '0;
            method_count_in = '0;
            space_count_in  = '0;
            url_seen_in     = 1'b0;
            escape_in       = ESC_NONE;
            escape_high_in  = '0;
            proto_chars_in  = '0;
            proto_count_in  = '0;
            version_in      = VER_PROTO;
            major_in        = '0;
            minor_in        = '0;
            error_in        = ERR_NONE;
            cr_pending_in   = 1'b0;
            digit_seen_in   = 1'b0;
         end else if (is_cr) begin
            cr_pending_in = 1'b1;
         end else if (is_space) begin
            space_count_in = space_next;
            if (space_next > 2'd2) begin
               error_in = ERR_FORMAT;
            end else begin
               if ((field_ff == FIELD_URL) && (escape_ff != ESC_NONE)) begin
                  if (error_ff == ERR_NONE) error_in = ERR_URL;
                  escape_in = ESC_NONE;
               end
               field_in = (field_ff == FIELD_METHOD) ? FIELD_URL : FIELD_VERSION;
            end
         end else if (field_ff == FIELD_METHOD) begin
            method_chars_in = {method_chars_ff[23:0], in_byte_ff};
            if (method_count_ff < 3'd5) method_count_in = method_count_ff + 3'd1;
         end else if (field_ff == FIELD_URL) begin
            url_seen_in = 1'b1;
            error_in    = url_err_base;
            unique case (escape_ff)
               ESC_NONE: begin
                  if (in_byte_ff == CHAR_PERCENT) escape_in = ESC_HIGH;
                  else if (in_byte_ff[7] && (url_err_base == ERR_NONE)) error_in = ERR_URL;
               end
               ESC_HIGH: begin
                  if (hex_nib[4]) begin
                     if (url_err_base == ERR_NONE) error_in = ERR_URL;
                     escape_in = ESC_NONE;
                  end else begin
                     escape_high_in = hex_nib[3:0];
                     escape_in      = ESC_LOW;
                  end
               end
               ESC_LOW: begin
                  escape_in = ESC_NONE;
                  if ((hex_nib[4] || esc_value[7]) && (url_err_base == ERR_NONE))
                     error_in = ERR_URL;
               end
               default: escape_in = ESC_NONE;
            endcase
         end else begin
            unique case (version_ff)
               VER_PROTO: begin
                  if (in_byte_ff == CHAR_SLASH) begin
                     if ((proto_count_ff == 3'd4) && (proto_chars_ff == WORD_HTTP)) begin
                        version_in    = VER_MAJOR;
                        digit_seen_in = 1'b0;
                     end else begin
                        error_in   = ERR_FORMAT;
                        version_in = VER_BAD;
                     end
                  end else begin
                     proto_chars_in = {proto_chars_ff[23:0], in_byte_ff};
                     if (proto_count_ff < 3'd5) proto_count_in = proto_count_ff + 3'd1;
                  end
               end
               VER_MAJOR: begin
                  if (is_digit) begin
                     major_in      = add_digit(major_ff, in_byte_ff[3:0]);
                     digit_seen_in = 1'b1;
                  end else if ((in_byte_ff == CHAR_DOT) && digit_seen_ff) begin
                     version_in    = VER_MINOR;
                     digit_seen_in = 1'b0;
                  end else begin
                     error_in   = ERR_FORMAT;
                     version_in = VER_BAD;
                  end
               end
               VER_MINOR: begin
                  if (is_digit) begin
                     minor_in      = add_digit(minor_ff, in_byte_ff[3:0]);
                     digit_seen_in = 1'b1;
                  end else begin
                     error_in   = ERR_FORMAT;
                     version_in = VER_BAD;
                  end
               end
               VER_BAD: version_in = VER_BAD;
               default: version_in = VER_BAD;
            endcase
         end
      end
   end

   // result fields
   always_comb begin
      url_valid_in = url_emit;
      url_char_in  = url_emit ? ((escape_ff == ESC_NONE) ? in_byte_ff[CharWidth-1:0]
                                                          : esc_value[CharWidth-1:0])
                              : '0;
      line_done_in = line_end;
      status_in    = STATUS_OK;
      method_in    = METHOD_GET;
      ver_major_in = '0;
      ver_minor_in = '0;
      if (line_end) begin
         priority if (forced_end) status_in = STATUS_BAD_ENDING;
         else if (line_fmt_bad)   status_in = STATUS_BAD_LINE;
         else if (line_url_bad)   status_in = STATUS_BAD_ESCAPE;
         else                     status_in = STATUS_OK;
         if (status_in == STATUS_OK) begin
            priority if (get_ok) method_in = METHOD_GET;
            else if (head_ok)    method_in = METHOD_HEAD;
            else                 method_in = METHOD_POST;
            ver_major_in = major_ff;
            ver_minor_in = minor_ff;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         field_ff        <= FIELD_METHOD;
         method_chars_ff <= '0;
         method_count_ff <= '0;
         space_count_ff  <= '0;
         url_seen_ff     <= 1'b0;
         escape_ff       <= ESC_NONE;
         escape_high_ff  <= '0;
         proto_chars_ff  <= '0;
         proto_count_ff  <= '0;
         version_ff      <= VER_PROTO;
         major_ff        <= '0;
         minor_ff        <= '0;
         error_ff        <= ERR_NONE;
         cr_pending_ff   <= 1'b0;
         digit_seen_ff   <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         if (advance)         rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         field_ff        <= field_in;
         method_chars_ff <= method_chars_in;
         method_count_ff <= method_count_in;
         space_count_ff  <= space_count_in;
         url_seen_ff     <= url_seen_in;
         escape_ff       <= escape_in;
         escape_high_ff  <= escape_high_in;
         proto_chars_ff  <= proto_chars_in;
         proto_count_ff  <= proto_count_in;
         version_ff      <= version_in;
         major_ff        <= major_in;
         minor_ff        <= minor_in;
         error_ff        <= error_in;
         cr_pending_ff   <= cr_pending_in;
         digit_seen_ff   <= digit_seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata;
      if (advance) begin
         url_valid_ff <= url_valid_in;
         url_char_ff  <= url_char_in;
         line_done_ff <= line_done_in;
         status_ff    <= status_in;
         method_ff    <= method_in;
         ver_major_ff <= ver_major_in;
         ver_minor_ff <= ver_minor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = url_valid_ff;
   assign rsp_tlast  = line_done_ff;
   assign rsp_tdata  = {1'b0, ver_minor_ff, ver_major_ff, method_ff, status_ff, url_char_ff};

endmodule

FILE: src/hrlp_checker.sv
module hrlp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hrlp_pkg::RspDataWidth-1:0]  rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);
   import hrlp_pkg::*;

   // a URL byte never rides on the line end transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tlast))
      else $error("url byte and line end in one transaction");

   // without a URL byte the character field is zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[6:0] == 7'd0))
      else $error("url_char set without url_valid");

   // method and version only on a clean line end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (!rsp_tlast || (rsp_tdata[8:7] != STATUS_OK))) |->
         (rsp_tdata[31:9] == 23'd0))
      else $error("method or version reported without a good line");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind http_request_line_parser_unit hrlp_checker u_hrlp_checker (.*);

FILE: dv/http_request_line_parser_unit_test.sv
module http_request_line_parser_unit_test;
   import hrlp_pkg::*;

   typedef struct packed {
      logic                    url_valid;
      logic [CharWidth-1:0]    url_char;
      logic                    line_done;
      status_type              status;
      request_method_type      method;
      logic [VersionWidth-1:0] major;
      logic [VersionWidth-1:0] minor;
   } line_result_type;

   typedef enum int {
      FLAW_NONE,
      FLAW_METHOD,
      FLAW_SPACING,
      FLAW_URL_START,
      FLAW_ESCAPE,
      FLAW_PROTOCOL,
      FLAW_VERSION,
      FLAW_ENDING
   } flaw_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_QUARTER,
      READY_MOSTLY
   } ready_mode_type;

   localparam int HoldCycles = 300;
   localparam int HoldAfter  = 150;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ByteWidth-1:0]    req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   logic [ByteWidth-1:0] line_bytes[$];
   line_result_type      byte_outcomes[$];
   line_result_type      predicted;
   line_result_type      want;

   // parser state
   field_type               fld;
   logic [31:0]             meth_word;
   logic [2:0]              meth_len;
   logic [1:0]              spaces;
   logic                    url_seen;
   escape_type              esc;
   logic [3:0]              esc_hi;
   logic [31:0]             proto_word;
   logic [2:0]              proto_len;
   version_type             vph;
   logic [VersionWidth-1:0] major_acc;
   logic [VersionWidth-1:0] minor_acc;
   error_type               err;
   logic                    cr_seen;
   logic                    digit_seen;

   int error_count = 0;
   int results_checked = 0;
   int bytes_sent = 0;
   int lines_closed = 0;
   int url_bytes = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int cycle_count = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   http_request_line_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic clear_line();
      fld        = FIELD_METHOD;
      meth_word  = '0;
      meth_len   = '0;
      spaces     = '0;
      url_seen   = 1'b0;
      esc        = ESC_NONE;
      esc_hi     = '0;
      proto_word = '0;
      proto_len  = '0;
      vph        = VER_PROTO;
      major_acc  = '0;
      minor_acc  = '0;
      err        = ERR_NONE;
      cr_seen    = 1'b0;
      digit_seen = 1'b0;
   endtask

   // a format error always wins over a URL error
   task automatic flag_url_error();
      if (err == ERR_NONE) err = ERR_URL;
   endtask

   function automatic logic [VersionWidth-1:0] bump_version(
      input logic [VersionWidth-1:0] v,
      input logic [3:0]              d
   );
      int n;
      n = int'(v) * 10 + int'(d);
      if (n > int'(VERSION_MAX)) n = int'(VERSION_MAX);
      return n[VersionWidth-1:0];
   endfunction

   task automatic close_line(input logic bad_end, inout line_result_type r);
      request_method_type code;
      logic               method_ok;
      code      = METHOD_GET;
      method_ok = 1'b1;
      if (meth_len == 3'd3 && meth_word == WORD_GET) code = METHOD_GET;
      else if (meth_len == 3'd4 && meth_word == WORD_HEAD) code = METHOD_HEAD;
      else if (meth_len == 3'd4 && meth_word == WORD_POST) code = METHOD_POST;
      else method_ok = 1'b0;
      r.line_done = 1'b1;
      if (bad_end) begin
         r.status = STATUS_BAD_ENDING;
      end else if (err == ERR_FORMAT || spaces != 2'd2 || !method_ok || !url_seen ||
                   vph != VER_MINOR || !digit_seen) begin
         r.status = STATUS_BAD_LINE;
      end else if (err == ERR_URL || esc != ESC_NONE) begin
         r.status = STATUS_BAD_ESCAPE;
      end else begin
         r.status = STATUS_OK;
         r.method = code;
         r.major  = major_acc;
         r.minor  = minor_acc;
      end
      clear_line();
   endtask

   task automatic parse_byte(input logic [ByteWidth-1:0] b, output line_result_type r);
      logic [4:0] hv;
      logic [7:0] val;
      logic       digit;
      r     = '0;
      digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) hv = {1'b0, b[3:0]};
      else if (b >= "A" && b <= "F") hv = 5'(b - "A" + 10);
      else if (b >= "a" && b <= "f") hv = 5'(b - "a" + 10);
      else hv = 5'd16;

      if (cr_seen) begin
         cr_seen = 1'b0;
         close_line(b != CHAR_LF, r);
      end else if (b == CHAR_CR) begin
         cr_seen = 1'b1;
      end else if (b == CHAR_LF) begin
         close_line(1'b1, r);
      end else if (b == CHAR_SPACE) begin
         if (spaces < 2'd3) spaces++;
         if (spaces == 2'd3) begin
            err = ERR_FORMAT;
         end else begin
            // a space cuts off an open escape
            if (fld == FIELD_URL && esc != ESC_NONE) begin
               flag_url_error();
               esc = ESC_NONE;
            end
            fld = field_type'(fld + 2'd1);
         end
      end else begin
         case (fld)
            FIELD_METHOD: begin
               meth_word = {meth_word[23:0], b};
               if (meth_len < 3'd5) meth_len++;
            end
            FIELD_URL: begin
               if (!url_seen) begin
                  url_seen = 1'b1;
                  if (b != CHAR_SLASH) err = ERR_FORMAT;
               end
               if (esc == ESC_NONE) begin
                  if (b == CHAR_PERCENT) esc = ESC_HIGH;
                  else if (b[7]) flag_url_error();
                  else if (err != ERR_URL) begin
                     r.url_valid = 1'b1;
                     r.url_char  = b[6:0];
                  end
               end else if (hv[4]) begin
                  flag_url_error();
                  esc = ESC_NONE;
               end else if (esc == ESC_HIGH) begin
                  esc_hi = hv[3:0];
                  esc    = ESC_LOW;
               end else begin
                  esc = ESC_NONE;
                  val = {esc_hi, hv[3:0]};
                  if (val[7]) flag_url_error();
                  else if (err != ERR_URL) begin
                     r.url_valid = 1'b1;
                     r.url_char  = val[6:0];
                  end
               end
            end
            default: begin
               case (vph)
                  VER_PROTO: begin
                     if (b == CHAR_SLASH) begin
                        if (proto_len == 3'd4 && proto_word == WORD_HTTP) begin
                           vph        = VER_MAJOR;
                           digit_seen = 1'b0;
                        end else begin
                           err = ERR_FORMAT;
                           vph = VER_BAD;
                        end
                     end else begin
                        proto_word = {proto_word[23:0], b};
                        if (proto_len < 3'd5) proto_len++;
                     end
                  end
                  VER_MAJOR: begin
                     if (digit) begin
                        major_acc  = bump_version(major_acc, b[3:0]);
                        digit_seen = 1'b1;
                     end else if (b == CHAR_DOT && digit_seen) begin
                        vph        = VER_MINOR;
                        digit_seen = 1'b0;
                     end else begin
                        err = ERR_FORMAT;
                        vph = VER_BAD;
                     end
                  end
                  VER_MINOR: begin
                     if (digit) begin
                        minor_acc  = bump_version(minor_acc, b[3:0]);
                        digit_seen = 1'b1;
                     end else begin
                        err = ERR_FORMAT;
                        vph = VER_BAD;
                     end
                  end
                  default: ;
               endcase
            end
         endcase
      end
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return CHAR_ZERO + nib;
      return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   task automatic push_digits(input int n);
      repeat (n) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_escape(input logic [7:0] v);
      line_bytes.push_back(CHAR_PERCENT);
      line_bytes.push_back(hex_char(v[7:4], $urandom_range(0, 1)));
      line_bytes.push_back(hex_char(v[3:0], $urandom_range(0, 1)));
   endtask

   task automatic push_bad_url_piece();
      string junk;
      junk = "gGzZ:@/.~-";
      case ($urandom_range(0, 4))
         0: begin
            line_bytes.push_back(CHAR_PERCENT);
            line_bytes.push_back(junk[$urandom_range(0, junk.len() - 1)]);
         end
         1: push_escape(8'($urandom_range(128, 255)));
         2: line_bytes.push_back(8'($urandom_range(128, 255)));
         3: line_bytes.push_back(CHAR_PERCENT);
         default: begin
            line_bytes.push_back(CHAR_PERCENT);
            line_bytes.push_back(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)));
         end
      endcase
   endtask

   task automatic push_good_url_piece();
      int          pick;
      logic [7:0]  v;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         do v = 8'($urandom_range(33, 126)); while (v == CHAR_PERCENT);
         line_bytes.push_back(v);
      end else if (pick < 9) begin
         push_escape(8'($urandom_range(0, 127)));
      end else begin
         // raw controls and DEL pass through undecoded
         do v = 8'($urandom_range(0, 127));
         while (v == CHAR_PERCENT || v == CHAR_SPACE || v == CHAR_CR || v == CHAR_LF);
         line_bytes.push_back(v);
      end
   endtask

   task automatic add_line(input flaw_type flaw);
      int         count;
      int         bad_at;
      logic [7:0] v;
      string      protos[5];
      protos = '{"HTTPS", "HTT", "http", "HTTX", ""};

      if (flaw == FLAW_METHOD) begin
         repeat ($urandom_range(0, 5)) line_bytes.push_back(8'($urandom_range("A", "Z")));
      end else begin
         case ($urandom_range(0, 2))
            0: push_text("GET");
            1: push_text("HEAD");
            default: push_text("POST");
         endcase
      end

      if (flaw == FLAW_SPACING) begin
         if ($urandom_range(0, 1)) push_text("  ");
      end else begin
         line_bytes.push_back(CHAR_SPACE);
      end

      count = $urandom_range(0, 6);
      if (flaw == FLAW_URL_START) begin
         if ($urandom_range(0, 2) != 0) begin
            do v = 8'($urandom_range(33, 126)); while (v == CHAR_SLASH);
            line_bytes.push_back(v);
         end else begin
            count = 0;
         end
      end else begin
         line_bytes.push_back(CHAR_SLASH);
      end
      bad_at = (flaw == FLAW_ESCAPE) ? $urandom_range(0, count) : -1;
      for (int i = 0; i <= count; i++) begin
         if (i == bad_at) push_bad_url_piece();
         if (i < count) push_good_url_piece();
      end
      line_bytes.push_back(CHAR_SPACE);

      if (flaw == FLAW_PROTOCOL) push_text(protos[$urandom_range(0, 4)]);
      else push_text("HTTP");
      line_bytes.push_back(CHAR_SLASH);

      if (flaw == FLAW_VERSION) begin
         case ($urandom_range(0, 4))
            0: begin
               line_bytes.push_back(CHAR_DOT);
               push_digits($urandom_range(1, 2));
            end
            1: push_digits($urandom_range(1, 3));
            2: begin
               push_digits($urandom_range(1, 2));
               line_bytes.push_back(CHAR_DOT);
            end
            3: begin
               push_digits(1);
               line_bytes.push_back(CHAR_DOT);
               push_digits(1);
               line_bytes.push_back(8'($urandom_range("a", "z")));
               push_digits($urandom_range(0, 2));
            end
            default: begin
               push_digits(1);
               push_text("..");
               push_digits(1);
            end
         endcase
      end else begin
         push_digits($urandom_range(1, ($urandom_range(0, 5) == 0) ? 4 : 2));
         line_bytes.push_back(CHAR_DOT);
         push_digits($urandom_range(1, ($urandom_range(0, 5) == 0) ? 4 : 2));
      end

      if (flaw == FLAW_ENDING) begin
         case ($urandom_range(0, 3))
            0: line_bytes.push_back(CHAR_LF);
            1: begin
               line_bytes.push_back(CHAR_CR);
               do v = 8'($urandom_range(0, 255)); while (v == CHAR_LF);
               line_bytes.push_back(v);
            end
            2: push_text(" \r\n");
            default: push_text("\r\r");
         endcase
      end else begin
         push_text("\r\n");
      end
   endtask

   // driver: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (line_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= line_bytes.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   // receiver: its own stall pattern, plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_checked >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            if (cycle_count % 64 == 0) ready_mode = ready_mode_type'($urandom_range(0, 3));
            case (ready_mode)
               READY_ALWAYS:  rsp_tready <= 1'b1;
               READY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               READY_QUARTER: rsp_tready <= (cycle_count % 4 == 0);
               default:       rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  results_checked, what, got, exp_val);
   endtask

   // monitor: predict on every byte transaction, check every result transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_sent++;
            parse_byte(req_tdata, predicted);
            byte_outcomes.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (byte_outcomes.size() == 0) begin
               report_mismatch("result with no byte pending", int'(rsp_tdata), 0);
            end else begin
               want = byte_outcomes.pop_front();
               if (rsp_tuser !== want.url_valid)
                  report_mismatch("url_valid", rsp_tuser, want.url_valid);
               if (rsp_tdata[6:0] !== want.url_char)
                  report_mismatch("url_char", rsp_tdata[6:0], want.url_char);
               if (rsp_tlast !== want.line_done)
                  report_mismatch("line_done", rsp_tlast, want.line_done);
               if (rsp_tdata[8:7] !== want.status)
                  report_mismatch("status", rsp_tdata[8:7], int'(want.status));
               if (rsp_tdata[10:9] !== want.method)
                  report_mismatch("method_code", rsp_tdata[10:9], int'(want.method));
               if (rsp_tdata[20:11] !== want.major)
                  report_mismatch("version_major", rsp_tdata[20:11], want.major);
               if (rsp_tdata[30:21] !== want.minor)
                  report_mismatch("version_minor", rsp_tdata[30:21], want.minor);
               if (rsp_tdata[31] !== 1'b0)
                  report_mismatch("spare bit", rsp_tdata[31], 0);
               if (want.url_valid) url_bytes++;
               if (want.line_done) begin
                  lines_closed++;
                  status_seen[want.status]++;
               end
            end
            results_checked++;
         end
      end
   end

   initial begin
      #(8 * 200000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      clear_line();

      // LF alone, CR followed by a stray byte, then a clean line with max escape
      // and a saturating minor version
      line_bytes.push_back(CHAR_LF);
      line_bytes.push_back(CHAR_CR);
      line_bytes.push_back(8'hFF);
      push_text("GET /%7f HTTP/1.1234\r\n");

      while (line_bytes.size() < 520) begin
         case ($urandom_range(0, 19)) inside
            [0:11]: add_line(FLAW_NONE);
            [12:18]: add_line(flaw_type'($urandom_range(1, 7)));
            default: begin
               repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
               push_text("\r\n");
            end
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (line_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (byte_outcomes.size() != 0) @(posedge clock);
      // give a stray extra result time to show up
      repeat (6) @(posedge clock);

      $display(
         "covered %0d bytes, %0d lines: %0d ok, %0d bad line, %0d bad escape, %0d bad end",
         bytes_sent, lines_closed, status_seen[STATUS_OK], status_seen[STATUS_BAD_LINE],
         status_seen[STATUS_BAD_ESCAPE], status_seen[STATUS_BAD_ENDING]);
      $display("%0d decoded URL bytes checked, %0d results in all, %0d mismatches",
               url_bytes, results_checked, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
src/hrlp_pkg.sv
src/http_request_line_parser_unit.sv
src/hrlp_checker.sv
dv/http_request_line_parser_unit_test.sv
